>>> hw/rtl/integer_to_ascii_radix_macros.svh
// ----------------------------------------------------------------------------
// integer_to_ascii_radix assertion macros
// shared property shorthands, clocked on clk, quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ITOA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/itoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// shared widths, character codes, controller types and helper functions
// ----------------------------------------------------------------------------
package itoa_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int RADIX_W     = 6;
	localparam int CHAR_W      = 8;
	localparam int DIGIT_W     = RADIX_W;
	localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
	localparam int STK_DEPTH   = VALUE_WIDTH;
	localparam int STK_IDX_W   = $clog2(STK_DEPTH);
	localparam int STK_CNT_W   = $clog2(STK_DEPTH + 1);

	localparam logic [CHAR_W-1:0]  CH_ZERO      = 8'h30;
	localparam logic [CHAR_W-1:0]  CH_LOWER_A   = 8'h61;
	localparam logic [CHAR_W-1:0]  CH_MINUS     = 8'h2D;
	localparam logic [RADIX_W-1:0] DECIMAL_BASE = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN    = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX    = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET  = DECIMAL_BASE;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUSH,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic push;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic div_last;
		logic quo_zero;
		logic neg;
		logic cnt_one;
	} status_t;

	function automatic logic [RADIX_W-1:0] clamp_base(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] b;
		b = r;
		if (r < RADIX_MIN) b = RADIX_MIN;
		if (r > RADIX_MAX) b = RADIX_MAX;
		return b;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DECIMAL_BASE) begin
			c = CH_ZERO + CHAR_W'(d);
		end else begin
			c = CH_LOWER_A + CHAR_W'(d - DECIMAL_BASE);
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/itoa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_ctrl
// sequencer: divide, push digit, repeat until quotient is zero, then emit
// ----------------------------------------------------------------------------
module itoa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  itoa_pkg::status_t  status,
	output itoa_pkg::cmd_t     cmd,
	output logic               busy
);

	itoa_pkg::state_t state_q;
	itoa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itoa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			itoa_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = itoa_pkg::ST_DIV;
				end
			end
			itoa_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) state_d = itoa_pkg::ST_PUSH;
			end
			itoa_pkg::ST_PUSH: begin
				cmd.push = 1'b1;
				if (!status.quo_zero) begin
					state_d = itoa_pkg::ST_DIV;
				end else if (status.neg) begin
					state_d = itoa_pkg::ST_SIGN;
				end else begin
					state_d = itoa_pkg::ST_EMIT;
				end
			end
			itoa_pkg::ST_SIGN: begin
				cmd.emit_sign = 1'b1;
				state_d       = itoa_pkg::ST_EMIT;
			end
			itoa_pkg::ST_EMIT: begin
				cmd.emit_digit = 1'b1;
				if (status.cnt_one) state_d = itoa_pkg::ST_IDLE;
			end
			default: begin
				state_d = itoa_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != itoa_pkg::ST_IDLE);

endmodule

>>> hw/rtl/itoa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_dp
// radix register, bit-serial divider, digit stack and output register
// ----------------------------------------------------------------------------
module itoa_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [itoa_pkg::RADIX_W-1:0]        cfg_data,
	input  logic [itoa_pkg::VALUE_WIDTH-1:0]    value,
	input  itoa_pkg::cmd_t                      cmd,
	output itoa_pkg::status_t                   status,
	output logic                                strobe,
	output logic [itoa_pkg::CHAR_W-1:0]         character,
	output logic                                last_char
);

	localparam int VW = itoa_pkg::VALUE_WIDTH;
	localparam int RW = itoa_pkg::RADIX_W;

	logic [RW-1:0]                   radix_q;
	logic [RW-1:0]                   base_q;
	logic                            neg_q;
	logic [VW-1:0]                   mag_q;
	logic [RW-1:0]                   rem_q;
	logic [itoa_pkg::BIT_CNT_W-1:0]  bit_cnt_q;
	logic [itoa_pkg::STK_CNT_W-1:0]  cnt_q;
	logic [itoa_pkg::DIGIT_W-1:0]    stk_q [itoa_pkg::STK_DEPTH];
	logic                            strobe_q;
	logic [itoa_pkg::CHAR_W-1:0]     char_q;
	logic                            last_q;

	logic [RW:0]                     trial;
	logic                            ge;
	logic [RW-1:0]                   rem_next;
	logic [VW-1:0]                   neg_val;
	logic                            is_neg;
	logic [itoa_pkg::STK_IDX_W-1:0]  rd_idx;
	logic [itoa_pkg::STK_IDX_W-1:0]  wr_idx;

	// one restoring division step
	assign trial    = {rem_q, mag_q[VW-1]};
	assign ge       = (trial >= {1'b0, base_q});
	assign rem_next = ge ? RW'(trial - {1'b0, base_q}) : RW'(trial);

	assign is_neg   = (itoa_pkg::clamp_base(radix_q) == itoa_pkg::DECIMAL_BASE) && value[VW-1];
	assign neg_val  = VW'(~value + 1'b1);

	assign wr_idx   = cnt_q[itoa_pkg::STK_IDX_W-1:0];
	assign rd_idx   = itoa_pkg::STK_IDX_W'(cnt_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= itoa_pkg::RADIX_RESET;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_we) radix_q <= cfg_data;
			strobe_q <= cmd.emit_sign | cmd.emit_digit;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.push) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.emit_digit) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q    <= itoa_pkg::clamp_base(radix_q);
			neg_q     <= is_neg;
			mag_q     <= is_neg ? neg_val : value;
			rem_q     <= '0;
			bit_cnt_q <= '0;
		end else if (cmd.div_step) begin
			mag_q     <= {mag_q[VW-2:0], ge};
			rem_q     <= rem_next;
			bit_cnt_q <= bit_cnt_q + 1'b1;
		end else if (cmd.push) begin
			stk_q[wr_idx] <= rem_q;
			rem_q         <= '0;
			bit_cnt_q     <= '0;
		end
		if (cmd.emit_sign) begin
			char_q <= itoa_pkg::CH_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= itoa_pkg::digit_char(stk_q[rd_idx]);
			last_q <= (cnt_q == itoa_pkg::STK_CNT_W'(1));
		end
	end

	assign status.div_last = (bit_cnt_q == itoa_pkg::BIT_CNT_W'(VW - 1));
	assign status.quo_zero = (mag_q == '0);
	assign status.neg      = neg_q;
	assign status.cnt_one  = (cnt_q == itoa_pkg::STK_CNT_W'(1));

	assign strobe    = strobe_q;
	assign character = char_q;
	assign last_char = last_q;

endmodule

>>> hw/rtl/integer_to_ascii_radix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// converts a signed integer to ascii text in base 2..36, one number an item
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low. the text comes out
// most significant digit first, one character a cycle, each on character with
// strobe high for exactly one cycle; last_char marks the final character. the
// receiver cannot stall, so it must take every strobe. digits above nine are
// lower-case letters. in base ten a negative value gets a leading '-'; in any
// other base the value is its unsigned two's-complement pattern. zero gives a
// single '0'. radix values below 2 or above 36 act as 2 or 36.
// each digit is worked out in the restoring divider, one quotient bit a cycle,
// then pushed onto the stack; only after the last push do the sign, if any,
// and the digits come out. busy drops as the last character is registered, so
// the next item may start while that character is still on the outputs.
// the radix register is written through cfg_valid/cfg_ready (always ready)
// and is sampled when an item is taken.
module integer_to_ascii_radix (
	input  logic                           clk,
	input  logic                           arst_n,
	// item input
	input  logic                           start,
	output logic                           busy,
	input  logic signed [31:0]             value,
	// radix register write
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [itoa_pkg::RADIX_W-1:0]   cfg_data,
	// character output
	output logic                           strobe,
	output logic [itoa_pkg::CHAR_W-1:0]    character,
	output logic                           last_char
);

	itoa_pkg::cmd_t    cmd;
	itoa_pkg::status_t status;
	logic              cfg_we;

	// register file is a single flop bank, always able to take a write
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	itoa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// only the low VALUE_WIDTH bits of the item take part
	itoa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.value     (value[itoa_pkg::VALUE_WIDTH-1:0]),
		.cmd       (cmd),
		.status    (status),
		.strobe    (strobe),
		.character (character),
		.last_char (last_char)
	);

endmodule

>>> hw/rtl/itoa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_checker
// port-level timing checks on the converter, bound to the top level
// ----------------------------------------------------------------------------
`include "integer_to_ascii_radix_macros.svh"

module itoa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          strobe,
	input logic [itoa_pkg::CHAR_W-1:0]   character,
	input logic                          last_char
);

	`ITOA_ASSERT_NEXT(a_take_busy, start && !busy, busy, "busy not raised after item taken")
	`ITOA_ASSERT_NEXT(a_take_quiet, start && !busy, !strobe, "character right after item taken")
	`ITOA_ASSERT_NEXT(a_no_gap, strobe && !last_char, strobe, "gap inside a number's text")
	`ITOA_ASSERT_NEXT(a_end_quiet, strobe && last_char, !strobe, "character after final one")
	`ITOA_ASSERT_SAME(a_last_digit, strobe && last_char, character != itoa_pkg::CH_MINUS,
		"final character is a minus sign")

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.character (character),
	.last_char (last_char)
);

>>> verif/integer_to_ascii_radix_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_checker
// follows the item, radix and character channels, works out the text each
// accepted number should produce and compares every character as it comes
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [31:0]                    value,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [itoa_pkg::RADIX_W-1:0]   cfg_data,
	input  logic                           strobe,
	input  logic [itoa_pkg::CHAR_W-1:0]    character,
	input  logic                           last_char,
	output int                             mismatch_count,
	output int                             text_pending,
	output int                             chars_checked
);

	import itoa_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] glyph;
		logic              is_last;
	} glyph_t;

	glyph_t               text_q [$];
	logic [RADIX_W-1:0]   radix_shadow;

	// text of one number, most significant digit first
	task automatic predict_text(input logic [31:0] num, input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] base;
		logic [32:0]        mag;
		logic [RADIX_W-1:0] digit;
		logic [CHAR_W-1:0]  glyphs [0:32];
		int                 n;
		logic               negative;
		base = r;
		if (r < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			base = RADIX_MAX;
		end
		negative = (base == DECIMAL_BASE) && num[31];
		mag = negative ? (33'h1_0000_0000 - {1'b0, num}) : {1'b0, num};
		n = 0;
		do begin
			digit = RADIX_W'(mag % base);
			glyphs[n] = (digit < DECIMAL_BASE) ? CH_ZERO + CHAR_W'(digit)
				: CH_LOWER_A + CHAR_W'(digit - DECIMAL_BASE);
			n++;
			mag = mag / base;
		end while (mag != 0);
		if (negative) begin
			text_q.push_back('{glyph: CH_MINUS, is_last: 1'b0});
		end
		for (int i = n - 1; i >= 0; i--) begin
			text_q.push_back('{glyph: glyphs[i], is_last: (i == 0)});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		int     errs;
		glyph_t want;
		if (!arst_n) begin
			radix_shadow   <= RADIX_RESET;
			text_q.delete();
			mismatch_count <= 0;
			text_pending   <= 0;
			chars_checked  <= 0;
		end else begin
			errs = 0;
			// retire the oldest expectation first, a new number may start on the same edge
			if (strobe) begin
				if (text_q.size() == 0) begin
					$error("character 0x%02h arrived with nothing outstanding", character);
					errs++;
				end else begin
					want = text_q.pop_front();
					if (character !== want.glyph) begin
						$error("character: expected 0x%02h, got 0x%02h", want.glyph, character);
						errs++;
					end
					if (last_char !== want.is_last) begin
						$error("last_char: expected %0b, got %0b", want.is_last, last_char);
						errs++;
					end
				end
				chars_checked <= chars_checked + 1;
			end
			if (cfg_valid && cfg_ready) begin
				radix_shadow <= cfg_data;
			end
			if (start && !busy) begin
				predict_text(value, radix_shadow);
			end
			mismatch_count <= mismatch_count + errs;
			text_pending   <= text_q.size();
		end
	end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives numbers and radix settings into the integer to ascii converter and
// reports the verdict; character checking happens in the checker beside the block
// ----------------------------------------------------------------------------
module tb_top;

	import itoa_pkg::*;

	// longest correct silence is the division of one 32-digit base-two number
	localparam int STALL_LIMIT = 6000;
	// cycles allowed after the last character before touching the radix
	localparam int SETTLE      = 4;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic [31:0]          value     = '0;
	logic                 cfg_valid = 1'b0;
	logic [RADIX_W-1:0]   cfg_data  = '0;
	logic                 busy;
	logic                 cfg_ready;
	logic                 strobe;
	logic [CHAR_W-1:0]    character;
	logic                 last_char;

	int mismatch_count;
	int text_pending;
	int chars_checked;
	int numbers_sent;
	int radix_writes;
	int quiet_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	integer_to_ascii_radix i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.strobe    (strobe),
		.character (character),
		.last_char (last_char)
	);

	integer_to_ascii_radix_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.value          (value),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.strobe         (strobe),
		.character      (character),
		.last_char      (last_char),
		.mismatch_count (mismatch_count),
		.text_pending   (text_pending),
		.chars_checked  (chars_checked)
	);

	// watchdog: any handshake on any channel counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$error("no handshake for %0d cycles", STALL_LIMIT);
				$display("Verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

	// hold start high until the converter takes the item
	task automatic send_number(input logic [31:0] num);
		start <= 1'b1;
		value <= num;
		do @(posedge clk); while (busy);
		numbers_sent++;
	endtask

	// drop start and let the converter finish every character it owes
	task automatic wait_drained();
		start <= 1'b0;
		value <= $urandom();
		do @(posedge clk); while (busy || text_pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// radix is only ever changed while the converter sits idle
	task automatic set_radix(input logic [RADIX_W-1:0] r);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		radix_writes++;
	endtask

	// sender gap: mostly short, now and then long enough to span a conversion
	task automatic maybe_idle(input int idle_pct);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			value <= $urandom();
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(20, 500)) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	function automatic logic [31:0] pick_number();
		logic [31:0] n;
		case ($urandom_range(0, 7))
			0: n = $urandom_range(0, 40);
			1: n = -$urandom_range(1, 40);
			2: n = 32'h8000_0000 + $urandom_range(0, 3);
			3: n = 32'h7fff_ffff - $urandom_range(0, 3);
			default: n = $urandom();
		endcase
		return n;
	endfunction

	// saturating corners, plain decimal, and anything the six bits allow
	function automatic logic [RADIX_W-1:0] pick_radix();
		logic [RADIX_W-1:0] r;
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 5))
					0: r = 6'd0;
					1: r = 6'd1;
					2: r = RADIX_MIN;
					3: r = RADIX_MAX;
					4: r = RADIX_MAX + 6'd1;
					default: r = 6'd63;
				endcase
			end
			1: r = DECIMAL_BASE;
			default: r = RADIX_W'($urandom_range(0, 63));
		endcase
		return r;
	endfunction

	initial begin : stimulus
		int idle_pct;
		numbers_sent = 0;
		radix_writes = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// decimal at the reset radix: zero, signs, both ends of the range
		send_number(32'd0);
		send_number(32'd1);
		send_number(32'hffff_ffff);
		send_number(32'h7fff_ffff);
		send_number(32'h8000_0000);
		send_number(32'd9);
		send_number(32'd10);
		send_number(-32'd10);
		send_number(32'd1234567890);

		// base two: all ones, lone top bit, zero
		set_radix(RADIX_MIN);
		send_number(32'hffff_ffff);
		send_number(32'h8000_0000);
		send_number(32'd0);

		// base 36: letters as digits, 'z' as top digit
		set_radix(RADIX_MAX);
		send_number(32'd35);
		send_number(32'd36);
		send_number(32'hffff_ffff);
		send_number(32'h7fff_ffff);

		// hex keeps negatives unsigned
		set_radix(6'd16);
		send_number(32'hdead_beef);
		send_number(32'h8000_0000);

		// radix outside 2..36 saturates
		set_radix(6'd0);
		send_number(32'd5);
		set_radix(6'd1);
		send_number(32'hffff_ffff);
		set_radix(6'd63);
		send_number(32'hffff_ffff);
		set_radix(RADIX_MAX + 6'd1);
		send_number(32'd1295);

		// random part in thirteen radix settings: light idling, heavy idling, then none
		for (int seg = 0; seg < 13; seg++) begin
			idle_pct = (seg < 4) ? 27 : (seg < 8) ? 74 : 0;
			set_radix(pick_radix());
			for (int k = 0; k < 30; k++) begin
				// sender holds back until the converter has said everything
				if (k == 15 && seg % 3 == 0) begin
					wait_drained();
				end
				maybe_idle(idle_pct);
				send_number(pick_number());
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);

		if (text_pending != 0) begin
			$error("%0d characters never arrived", text_pending);
		end
		$display("covered %0d numbers over %0d radix writes, %0d characters compared",
			numbers_sent, radix_writes, chars_checked);
		if (mismatch_count == 0 && text_pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_ctrl.sv
hw/rtl/itoa_dp.sv
hw/rtl/integer_to_ascii_radix.sv
hw/rtl/itoa_checker.sv
verif/integer_to_ascii_radix_checker.sv
verif/tb_top.sv
